// ----- sv/lolt_pkg.sv -----
// Shared types and sizing constants for the layered outpoint lookup table.
// No dependencies.
`default_nettype none
package lolt_pkg;
    localparam int OVL_N   = 64;
    localparam int MST_N   = 256;
    localparam int PND_N   = 32;
    localparam int OVL_AW  = $clog2(OVL_N);
    localparam int MST_AW  = $clog2(MST_N);
    localparam int PND_AW  = (PND_N > 1) ? $clog2(PND_N) : 1;
    localparam int ADDR_W  = (OVL_AW > MST_AW) ? ((OVL_AW > PND_AW) ? OVL_AW : PND_AW)
                                               : ((MST_AW > PND_AW) ? MST_AW : PND_AW);
    localparam int CNT_W   = ADDR_W + 1;
    localparam int PCNT_W  = $clog2(PND_N + 1);
    localparam int HASH_W  = 256;
    localparam int IDX_W   = 31;
    localparam int ID_W    = 63;
    localparam int ENTRY_W = HASH_W + IDX_W + ID_W;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_LOOKUP = 2'd1,
        CMD_INVAL  = 2'd2,
        CMD_COMMIT = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_PND_FULL = 2'd2,
        ST_OVERFLOW = 2'd3
    } t_status;

    typedef enum logic {TBL_OVL = 1'b0, TBL_MST = 1'b1} t_tbl;
    typedef enum logic {SCAN_KEY = 1'b0, SCAN_ID = 1'b1} t_scan_op;

    typedef struct packed {
        logic              load_in;
        logic              load_ovl;
        logic              load_pnd;
        logic              clr_scan;
        logic              scan_en;
        t_tbl              scan_tbl;
        t_scan_op          scan_op;
        logic              rd_ovl;
        logic              rd_mst;
        logic              rd_pnd;
        logic [ADDR_W-1:0] addr;
        logic              put;
        t_tbl              put_tbl;
        logic              push_pnd;
        logic              clr_commit;
        logic              out_load;
        logic              out_lookup;
        t_status           out_status;
    } t_dp_cmd;

    typedef struct packed {
        logic              match;
        logic              free;
        logic              pnd_full;
        logic [OVL_N-1:0]  ovl_valid;
        logic [PCNT_W-1:0] pnd_cnt;
    } t_dp_sts;
endpackage
`default_nettype wire

// ----- sv/lolt_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module lolt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

// ----- sv/lolt_dp.sv -----
// Datapath: entry memories, valid bits, pending list, scan compare and result payload.
// Depends on lolt_pkg and lolt_ram.
`default_nettype none
module lolt_dp
    import lolt_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire t_dp_cmd             i_cmd,
    input  wire logic [63:0]         i_hash_word_0,
    input  wire logic [63:0]         i_hash_word_1,
    input  wire logic [63:0]         i_hash_word_2,
    input  wire logic [63:0]         i_hash_word_3,
    input  wire logic [IDX_W-1:0]    i_output_index,
    input  wire logic [ID_W-1:0]     i_output_id,
    output t_dp_sts                  o_sts,
    output logic                     o_hit,
    output logic signed [63:0]       o_found_id,
    output logic [1:0]               o_status
);
    logic [HASH_W-1:0] r_key_hash;
    logic [IDX_W-1:0]  r_key_idx;
    logic [ID_W-1:0]   r_key_id;
    logic [OVL_N-1:0]  r_ovl_valid;
    logic [MST_N-1:0]  r_mst_valid;
    logic [PCNT_W-1:0] r_pnd_cnt;
    logic              r_s_en;
    t_tbl              r_s_tbl;
    t_scan_op          r_s_op;
    logic [ADDR_W-1:0] r_s_addr;
    logic              r_match;
    logic              r_free;
    logic [ADDR_W-1:0] r_match_addr;
    logic [ADDR_W-1:0] r_free_addr;
    logic [ID_W-1:0]   r_found_id;

    logic [ENTRY_W-1:0] ovl_rd;
    logic [ENTRY_W-1:0] mst_rd;
    logic [ID_W-1:0]    pnd_rd;
    logic [ENTRY_W-1:0] s_data;
    logic               s_valid;
    logic               key_eq;
    logic               id_eq;
    logic [ADDR_W-1:0]  put_addr;
    logic [ENTRY_W-1:0] put_data;

    assign s_data   = (r_s_tbl == TBL_MST) ? mst_rd : ovl_rd;
    assign s_valid  = (r_s_tbl == TBL_MST) ? r_mst_valid[r_s_addr[MST_AW-1:0]]
                                           : r_ovl_valid[r_s_addr[OVL_AW-1:0]];
    assign key_eq   = (s_data[ENTRY_W-1:ID_W] == {r_key_hash, r_key_idx});
    assign id_eq    = (s_data[ID_W-1:0] == r_key_id);
    assign put_addr = r_match ? r_match_addr : r_free_addr;
    assign put_data = {r_key_hash, r_key_idx, r_key_id};

    lolt_ram #(.WIDTH(ENTRY_W), .DEPTH(OVL_N)) u_ovl_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.put && (i_cmd.put_tbl == TBL_OVL)),
        .i_waddr (put_addr[OVL_AW-1:0]),
        .i_wdata (put_data),
        .i_re    (i_cmd.rd_ovl),
        .i_raddr (i_cmd.addr[OVL_AW-1:0]),
        .o_rdata (ovl_rd)
    );

    lolt_ram #(.WIDTH(ENTRY_W), .DEPTH(MST_N)) u_mst_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.put && (i_cmd.put_tbl == TBL_MST)),
        .i_waddr (put_addr[MST_AW-1:0]),
        .i_wdata (put_data),
        .i_re    (i_cmd.rd_mst),
        .i_raddr (i_cmd.addr[MST_AW-1:0]),
        .o_rdata (mst_rd)
    );

    lolt_ram #(.WIDTH(ID_W), .DEPTH(PND_N)) u_pnd_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.push_pnd),
        .i_waddr (r_pnd_cnt[PND_AW-1:0]),
        .i_wdata (r_key_id),
        .i_re    (i_cmd.rd_pnd),
        .i_raddr (i_cmd.addr[PND_AW-1:0]),
        .o_rdata (pnd_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovl_valid <= '0;
            r_mst_valid <= '0;
            r_pnd_cnt   <= '0;
            r_s_en      <= 1'b0;
            r_match     <= 1'b0;
            r_free      <= 1'b0;
        end else begin
            r_s_en <= i_cmd.scan_en;
            if (i_cmd.clr_scan) begin
                r_match <= 1'b0;
                r_free  <= 1'b0;
            end else if (r_s_en && (r_s_op == SCAN_KEY)) begin
                if (s_valid && key_eq && !r_match) begin
                    r_match <= 1'b1;
                end
                if (!s_valid && !r_free) begin
                    r_free <= 1'b1;
                end
            end
            if (r_s_en && (r_s_op == SCAN_ID) && s_valid && id_eq) begin
                if (r_s_tbl == TBL_MST) begin
                    r_mst_valid[r_s_addr[MST_AW-1:0]] <= 1'b0;
                end else begin
                    r_ovl_valid[r_s_addr[OVL_AW-1:0]] <= 1'b0;
                end
            end
            if (i_cmd.put) begin
                if (i_cmd.put_tbl == TBL_MST) begin
                    r_mst_valid[put_addr[MST_AW-1:0]] <= 1'b1;
                end else begin
                    r_ovl_valid[put_addr[OVL_AW-1:0]] <= 1'b1;
                end
            end
            if (i_cmd.push_pnd) begin
                r_pnd_cnt <= r_pnd_cnt + PCNT_W'(1);
            end
            if (i_cmd.clr_commit) begin
                r_ovl_valid <= '0;
                r_pnd_cnt   <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_s_tbl  <= i_cmd.scan_tbl;
        r_s_op   <= i_cmd.scan_op;
        r_s_addr <= i_cmd.addr;
        if (r_s_en && (r_s_op == SCAN_KEY)) begin
            if (s_valid && key_eq && !r_match) begin
                r_match_addr <= r_s_addr;
                r_found_id   <= s_data[ID_W-1:0];
            end
            if (!s_valid && !r_free) begin
                r_free_addr <= r_s_addr;
            end
        end
        if (i_cmd.load_in) begin
            r_key_hash <= {i_hash_word_0, i_hash_word_1, i_hash_word_2, i_hash_word_3};
            r_key_idx  <= i_output_index;
            r_key_id   <= i_output_id;
        end else if (i_cmd.load_ovl) begin
            r_key_hash <= ovl_rd[ENTRY_W-1:IDX_W+ID_W];
            r_key_idx  <= ovl_rd[IDX_W+ID_W-1:ID_W];
            r_key_id   <= ovl_rd[ID_W-1:0];
        end else if (i_cmd.load_pnd) begin
            r_key_id <= pnd_rd;
        end
        if (i_cmd.out_load) begin
            o_hit      <= i_cmd.out_lookup && r_match;
            o_found_id <= (i_cmd.out_lookup && r_match) ? {1'b0, r_found_id} : '1;
            o_status   <= i_cmd.out_status;
        end
    end

    assign o_sts.match     = r_match;
    assign o_sts.free      = r_free;
    assign o_sts.pnd_full  = (r_pnd_cnt >= PCNT_W'(PND_N));
    assign o_sts.ovl_valid = r_ovl_valid;
    assign o_sts.pnd_cnt   = r_pnd_cnt;
endmodule
`default_nettype wire

// ----- sv/lolt_ctrl.sv -----
// Controller: sequences table scans, inserts, commit walk and result handshake.
// Depends on lolt_pkg.
`default_nettype none
module lolt_ctrl
    import lolt_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [1:0]  i_command,
    input  wire logic        i_table_select,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_wdata,
    input  wire t_dp_sts     i_sts,
    output t_dp_cmd          o_cmd
);
    typedef enum logic [3:0] {
        S_IDLE, S_SCAN, S_SWAIT, S_IPUT, S_LCHK, S_VPUSH, S_COCHK, S_COLOAD,
        S_CPUT, S_CPCHK, S_CPLOAD, S_CPNEXT, S_CCLR, S_DONE
    } t_state;

    t_state            r_state, n_state, r_ret, n_ret;
    t_tbl              r_tbl, n_tbl;
    t_scan_op          r_op, n_op;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [CNT_W-1:0]  r_slot, n_slot;
    t_status           r_status, n_status;
    logic              r_lookup, n_lookup;
    logic              r_link;
    logic              r_out_valid, n_out_valid;
    logic [CNT_W-1:0]  last;

    assign last        = (r_tbl == TBL_MST) ? CNT_W'(MST_N - 1) : CNT_W'(OVL_N - 1);
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_ret       = r_ret;
        n_tbl       = r_tbl;
        n_op        = r_op;
        n_cnt       = r_cnt;
        n_slot      = r_slot;
        n_status    = r_status;
        n_lookup    = r_lookup;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd            = '0;
        o_cmd.scan_tbl   = r_tbl;
        o_cmd.scan_op    = r_op;
        o_cmd.put_tbl    = r_tbl;
        o_cmd.out_lookup = r_lookup;
        o_cmd.out_status = r_status;
        o_cmd.addr       = r_slot[ADDR_W-1:0];
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    o_cmd.clr_scan = 1'b1;
                    n_status = ST_OK;
                    n_lookup = 1'b0;
                    n_cnt    = '0;
                    n_slot   = '0;
                    n_tbl    = t_tbl'(i_table_select);
                    unique case (t_cmd'(i_command))
                        CMD_INSERT: begin
                            n_op = SCAN_KEY;
                            n_ret = S_IPUT;
                            n_state = S_SCAN;
                        end
                        CMD_LOOKUP: begin
                            n_op = SCAN_KEY;
                            n_lookup = 1'b1;
                            n_ret = S_LCHK;
                            n_state = S_SCAN;
                        end
                        CMD_INVAL: begin
                            n_op = SCAN_ID;
                            if (i_table_select) begin
                                n_ret = S_DONE;
                                n_state = S_SCAN;
                            end else if (i_sts.pnd_full) begin
                                n_status = ST_PND_FULL;
                                n_state = S_DONE;
                            end else begin
                                n_ret = S_VPUSH;
                                n_state = S_SCAN;
                            end
                        end
                        CMD_COMMIT: begin
                            n_state = S_COCHK;
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_SCAN: begin
                o_cmd.scan_en = 1'b1;
                o_cmd.rd_ovl  = (r_tbl == TBL_OVL);
                o_cmd.rd_mst  = (r_tbl == TBL_MST);
                o_cmd.addr    = r_cnt[ADDR_W-1:0];
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == last) begin
                    n_state = S_SWAIT;
                end
            end
            S_SWAIT: n_state = r_ret;
            S_IPUT: begin
                if (i_sts.match || i_sts.free) begin
                    o_cmd.put = 1'b1;
                end else begin
                    n_status = ST_FULL;
                end
                n_state = S_DONE;
            end
            S_LCHK: begin
                if (i_sts.match || (r_tbl == TBL_MST) || !r_link) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.clr_scan = 1'b1;
                    n_tbl = TBL_MST;
                    n_cnt = '0;
                    n_state = S_SCAN;
                end
            end
            S_VPUSH: begin
                o_cmd.push_pnd = 1'b1;
                n_state = S_DONE;
            end
            S_COCHK: begin
                if (r_slot == CNT_W'(OVL_N)) begin
                    n_slot = '0;
                    n_state = S_CPCHK;
                end else if (i_sts.ovl_valid[r_slot[OVL_AW-1:0]]) begin
                    o_cmd.rd_ovl = 1'b1;
                    n_state = S_COLOAD;
                end else begin
                    n_slot = r_slot + CNT_W'(1);
                end
            end
            S_COLOAD: begin
                o_cmd.load_ovl = 1'b1;
                o_cmd.clr_scan = 1'b1;
                n_tbl = TBL_MST;
                n_op  = SCAN_KEY;
                n_cnt = '0;
                n_ret = S_CPUT;
                n_state = S_SCAN;
            end
            S_CPUT: begin
                if (i_sts.match || i_sts.free) begin
                    o_cmd.put = 1'b1;
                end else begin
                    n_status = ST_OVERFLOW;
                end
                n_slot = r_slot + CNT_W'(1);
                n_state = S_COCHK;
            end
            S_CPCHK: begin
                if (r_slot >= CNT_W'(i_sts.pnd_cnt)) begin
                    n_state = S_CCLR;
                end else begin
                    o_cmd.rd_pnd = 1'b1;
                    n_state = S_CPLOAD;
                end
            end
            S_CPLOAD: begin
                o_cmd.load_pnd = 1'b1;
                n_tbl = TBL_MST;
                n_op  = SCAN_ID;
                n_cnt = '0;
                n_ret = S_CPNEXT;
                n_state = S_SCAN;
            end
            S_CPNEXT: begin
                n_slot = r_slot + CNT_W'(1);
                n_state = S_CPCHK;
            end
            S_CCLR: begin
                o_cmd.clr_commit = 1'b1;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ret       <= S_IDLE;
            r_out_valid <= 1'b0;
            r_link      <= 1'b0;
            r_tbl       <= TBL_OVL;
            r_op        <= SCAN_KEY;
            r_cnt       <= '0;
            r_slot      <= '0;
            r_status    <= ST_OK;
            r_lookup    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ret       <= n_ret;
            r_out_valid <= n_out_valid;
            r_tbl       <= n_tbl;
            r_op        <= n_op;
            r_cnt       <= n_cnt;
            r_slot      <= n_slot;
            r_status    <= n_status;
            r_lookup    <= n_lookup;
            if (i_cfg_we) begin
                r_link <= i_cfg_wdata;
            end
        end
    end
endmodule
`default_nettype wire

// ----- sv/layered_outpoint_lookup_table.sv -----
// Top level of the layered outpoint lookup table.
// Depends on lolt_pkg, lolt_ctrl and lolt_dp.
//
// One item at a time; every item gives one result. Tables are scanned one entry per
// cycle through the entry RAMs: an overlay scan covers 64 entries and a master scan 256.
// Insert costs one scan of its table and invalidate at most one, lookup one or two
// scans, and commit one master scan per valid overlay entry and per pending id. A new
// item is taken while the previous result still waits in the output register.
`default_nettype none
module layered_outpoint_lookup_table
    import lolt_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic [1:0]         i_command,
    input  wire logic               i_table_select,
    input  wire logic [63:0]        i_hash_word_0,
    input  wire logic [63:0]        i_hash_word_1,
    input  wire logic [63:0]        i_hash_word_2,
    input  wire logic [63:0]        i_hash_word_3,
    input  wire logic [30:0]        i_output_index,
    input  wire logic [62:0]        i_output_id,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic                    o_hit,
    output logic signed [63:0]      o_found_id,
    output logic [1:0]              o_status,
    input  wire logic               i_cfg_we,
    input  wire logic               i_cfg_wdata
);
    t_dp_cmd cmd;
    t_dp_sts sts;

    lolt_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_command      (i_command),
        .i_table_select (i_table_select),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_sts          (sts),
        .o_cmd          (cmd)
    );

    lolt_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_hash_word_0  (i_hash_word_0),
        .i_hash_word_1  (i_hash_word_1),
        .i_hash_word_2  (i_hash_word_2),
        .i_hash_word_3  (i_hash_word_3),
        .i_output_index (i_output_index),
        .i_output_id    (i_output_id),
        .o_sts          (sts),
        .o_hit          (o_hit),
        .o_found_id     (o_found_id),
        .o_status       (o_status)
    );
endmodule
`default_nettype wire

// ----- sv/lolt_checker.sv -----
// Port-level checks for the layered outpoint lookup table, bound to the top level.
// Depends on lolt_pkg.
`default_nettype none
module lolt_checker
    import lolt_pkg::*;
(
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               o_out_valid,
    input wire logic               i_out_ready,
    input wire logic               o_hit,
    input wire logic signed [63:0] o_found_id,
    input wire logic [1:0]         o_status
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_found_id))
        else $error("result item changed while stalled");

    a_hit_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_hit |-> !o_found_id[63])
        else $error("hit with negative id");

    a_miss_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_hit |-> (o_found_id == -64'sd1))
        else $error("miss without all-ones id");

    a_hit_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_hit |-> (o_status == ST_OK))
        else $error("hit with error status");
endmodule

bind layered_outpoint_lookup_table lolt_checker u_lolt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_hit       (o_hit),
    .o_found_id  (o_found_id),
    .o_status    (o_status)
);
`default_nettype wire
